/* design/utd_pkg.sv */
`default_nettype none

package utd_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned CodeW  = 16;
   localparam int unsigned StatW  = 2;
   localparam int unsigned LenW   = 2;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrDatW = 16;

   // result status codes
   typedef enum logic [StatW-1:0] {
      ST_DONE = 2'd0,
      ST_NULL = 2'd1,
      ST_MORE = 2'd2,
      ST_ILL  = 2'd3
   } status_type;

   // input op codes
   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } op_type;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_UTF8_MODE  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SINGLE_MAX = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CODE_MAX   = 2'd2;

   localparam logic [ByteW-1:0] SINGLE_MAX_RST = 8'd127;
   localparam logic [CodeW-1:0] CODE_MAX_RST   = 16'd65533;
   localparam logic [CodeW-1:0] OVERLONG_MIN   = 16'h0800;

   // byte already classified by the front end
   typedef struct packed {
      op_type           op;
      logic [ByteW-1:0] data;
      logic             is_null;
      logic             is_ascii;
      logic             is_lead2;
      logic             is_lead3;
      logic             is_cont;
   } item_class_type;

   typedef struct packed {
      logic             utf8_mode;
      logic [ByteW-1:0] single_max;
      logic [CodeW-1:0] code_max;
   } cfg_type;

endpackage

`default_nettype wire

/* design/utf8_to_ucs2_decoder_top.sv */
// UTF-8 to UCS-2 decoder. One byte enters per req beat (req_op = 0), or an
// end marker (req_op = 1); every req beat gives exactly one rsp beat, in
// order: status 0 with a code point and its sequence length, 1 for a null
// byte or a clean end, 2 while a sequence waits for more bytes, 3 for an
// illegal sequence (which also drops any partial character). In UTF-8
// mode, sequences of one to three bytes are decoded; lead bytes 0x80-0xC1
// and 0xF0 and up, overlong three-byte forms, bad continuation bytes and
// values above code_max are rejected. Throughput is one byte per clock
// while rsp_ready stays high; a byte passes a queue slot, then the result
// register, before rsp_valid. The back end holds the sequence state.
// csr_ready is always high; csr writes belong only to idle periods.
`default_nettype none

module utf8_to_ucs2_decoder_top (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic [utd_pkg::ByteW-1:0]     req_byte_in,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [utd_pkg::StatW-1:0]          rsp_status,
   output logic [utd_pkg::CodeW-1:0]          rsp_code_point,
   output logic [utd_pkg::LenW-1:0]           rsp_seq_length,

   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [utd_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [utd_pkg::CsrDatW-1:0]   csr_data
);
   import utd_pkg::*;

   item_class_type front_item;
   item_class_type back_item;
   cfg_type        cfg;
   logic           q_full;
   logic           q_not_empty;
   logic           q_pop;
   logic           req_beat;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign req_beat  = req_valid && req_ready;

   utd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // front: stateless byte classification
   utd_front u_front (
      .op      (op_type'(req_op)),
      .byte_in (req_byte_in),
      .item    (front_item)
   );

   // two slots so the front keeps taking beats while the back stalls
   utd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_beat),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .not_empty (q_not_empty)
   );

   // back: sequence state and result register
   utd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .item_valid     (q_not_empty),
      .item           (back_item),
      .item_pop       (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length)
   );

endmodule

`default_nettype wire

/* design/utd_front.sv */
`default_nettype none

module utd_front (
   input  wire utd_pkg::op_type            op,
   input  wire logic [utd_pkg::ByteW-1:0]  byte_in,
   output utd_pkg::item_class_type         item
);
   import utd_pkg::*;

   always_comb begin
      item.op       = op;
      item.data     = byte_in;
      item.is_null  = (byte_in == 8'h00);
      item.is_ascii = (byte_in < 8'h80);
      item.is_lead2 = (byte_in >= 8'hC2) && (byte_in < 8'hE0);
      item.is_lead3 = (byte_in >= 8'hE0) && (byte_in < 8'hF0);
      item.is_cont  = ((byte_in & 8'hC0) == 8'h80);
   end

endmodule

`default_nettype wire

/* design/utd_queue.sv */
`default_nettype none

module utd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire utd_pkg::item_class_type push_item,
   output logic                         full,
   input  wire logic                    pop,
   output utd_pkg::item_class_type      pop_item,
   output logic                         not_empty
);
   import utd_pkg::*;

   item_class_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* design/utd_back.sv */
`default_nettype none

module utd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire utd_pkg::cfg_type           cfg,
   input  wire logic                       item_valid,
   input  wire utd_pkg::item_class_type    item,
   output logic                            item_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [utd_pkg::StatW-1:0]       rsp_status,
   output logic [utd_pkg::CodeW-1:0]       rsp_code_point,
   output logic [utd_pkg::LenW-1:0]        rsp_seq_length
);
   import utd_pkg::*;

   logic [1:0]       pend_ff,    pend_in;
   logic [CodeW-1:0] partial_ff, partial_in;
   logic [LenW-1:0]  seqlen_ff,  seqlen_in;

   logic             valid_ff;
   status_type       status_ff,  status_in;
   logic [CodeW-1:0] code_ff,    code_in;
   logic [LenW-1:0]  len_ff,     len_in;

   logic [1:0]       pend_dec;
   logic [CodeW-1:0] merged;
   logic             fail;

   assign item_pop       = item_valid && (!valid_ff || rsp_ready);
   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_code_point = code_ff;
   assign rsp_seq_length = len_ff;

   assign pend_dec = pend_ff - 2'd1;
   // partial value kept at final bit position
   assign merged = (pend_dec == 2'd1)
                 ? (partial_ff | {4'b0, item.data[5:0], 6'b0})
                 : (partial_ff | {10'b0, item.data[5:0]});

   always_comb begin
      pend_in    = pend_ff;
      partial_in = partial_ff;
      seqlen_in  = seqlen_ff;
      status_in  = ST_NULL;
      code_in    = '0;
      len_in     = '0;
      fail       = 1'b0;

      if (item.op == OP_END) begin
         if (cfg.utf8_mode && (pend_ff != 2'd0)) begin
            fail = 1'b1;
         end
      end else if (!cfg.utf8_mode) begin
         if (item.data > cfg.single_max) begin
            fail = 1'b1;
         end else if (!item.is_null) begin
            status_in = ST_DONE;
            code_in   = {8'b0, item.data};
            len_in    = 2'd1;
         end
      end else if (pend_ff == 2'd0) begin
         priority if (item.is_ascii) begin
            if (!item.is_null) begin
               status_in = ST_DONE;
               code_in   = {8'b0, item.data};
               len_in    = 2'd1;
            end
         end else if (item.is_lead2) begin
            pend_in    = 2'd1;
            partial_in = {5'b0, item.data[4:0], 6'b0};
            seqlen_in  = 2'd2;
            status_in  = ST_MORE;
         end else if (item.is_lead3) begin
            pend_in    = 2'd2;
            partial_in = {item.data[3:0], 12'b0};
            seqlen_in  = 2'd3;
            status_in  = ST_MORE;
         end else begin
            fail = 1'b1;
         end
      end else if (!item.is_cont) begin
         fail = 1'b1;
      end else if (pend_dec == 2'd0) begin
         if (merged > cfg.code_max) begin
            fail = 1'b1;
         end else begin
            pend_in    = 2'd0;
            partial_in = '0;
            seqlen_in  = '0;
            status_in  = ST_DONE;
            code_in    = merged;
            len_in     = seqlen_ff;
         end
      end else if (merged < OVERLONG_MIN) begin
         fail = 1'b1;
      end else begin
         pend_in    = pend_dec;
         partial_in = merged;
         status_in  = ST_MORE;
      end

      if (fail) begin
         pend_in    = '0;
         partial_in = '0;
         seqlen_in  = '0;
         status_in  = ST_ILL;
         code_in    = '0;
         len_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         partial_ff <= '0;
         seqlen_ff  <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (item_pop) begin
            pend_ff    <= pend_in;
            partial_ff <= partial_in;
            seqlen_ff  <= seqlen_in;
            valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         status_ff <= status_in;
         code_ff   <= code_in;
         len_ff    <= len_in;
      end
   end

endmodule

`default_nettype wire

/* design/utd_queue_wrap_note.sv */
`default_nettype none

// Config register file: three control registers written through the csr beat.
module utd_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [utd_pkg::CsrIdxW-1:0]   wr_index,
   input  wire logic [utd_pkg::CsrDatW-1:0]   wr_data,
   output utd_pkg::cfg_type                   cfg
);
   import utd_pkg::*;

   cfg_type cfg_ff;

   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.utf8_mode  <= 1'b1;
         cfg_ff.single_max <= SINGLE_MAX_RST;
         cfg_ff.code_max   <= CODE_MAX_RST;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_UTF8_MODE:  cfg_ff.utf8_mode  <= wr_data[0];
            CSR_SINGLE_MAX: cfg_ff.single_max <= wr_data[ByteW-1:0];
            CSR_CODE_MAX:   cfg_ff.code_max   <= wr_data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire
